// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is low.
`define SEM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Antecedent this cycle, consequent in the cycle after.
`define SEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/sem_pkg.sv =====
// ---------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the shared edge merge block.
// ---------------------------------------------------------------------------
package sem_pkg;

  localparam int FIELD_W = 32;
  localparam int TOL_W   = 16;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 2;

  localparam logic [TOL_W-1:0]  TOL_RESET      = 16'd1;
  localparam logic [APB_AW-1:0] ADDR_TOLERANCE = 2'd0;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_EDGE   = 1'b1;

  // control bits that travel with each edge command
  typedef struct packed {
    logic second;       // edge belongs to outline B
    logic outline_end;  // last command of its outline
  } cmd_ctl_t;

endpackage

// ===== hdl/sem_in_if.sv =====
// ---------------------------------------------------------------------------
// sem_in_if
// Input channel: one vertex or edge item per beat.
// ---------------------------------------------------------------------------
interface sem_in_if;
  logic                                valid;
  logic                                ready;
  logic                                item_kind;
  logic signed [sem_pkg::FIELD_W-1:0]  x_start;
  logic signed [sem_pkg::FIELD_W-1:0]  y_start;
  logic signed [sem_pkg::FIELD_W-1:0]  x_end;
  logic signed [sem_pkg::FIELD_W-1:0]  y_end;
  logic                                body_last;

  modport source (
    output valid, item_kind, x_start, y_start, x_end, y_end, body_last,
    input  ready
  );
  modport sink (
    input  valid, item_kind, x_start, y_start, x_end, y_end, body_last,
    output ready
  );
endinterface

// ===== hdl/sem_out_if.sv =====
// ---------------------------------------------------------------------------
// sem_out_if
// Result channel: one surviving edge (or the empty marker) per beat.
// ---------------------------------------------------------------------------
interface sem_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sem_pkg::FIELD_W-1:0]  out_x_start;
  logic signed [sem_pkg::FIELD_W-1:0]  out_y_start;
  logic signed [sem_pkg::FIELD_W-1:0]  out_x_end;
  logic signed [sem_pkg::FIELD_W-1:0]  out_y_end;
  logic                                from_second;
  logic                                none_left;
  logic                                overflowed;
  logic                                last_result;

  modport source (
    output valid, out_x_start, out_y_start, out_x_end, out_y_end,
           from_second, none_left, overflowed, last_result,
    input  ready
  );
  modport sink (
    input  valid, out_x_start, out_y_start, out_x_end, out_y_end,
           from_second, none_left, overflowed, last_result,
    output ready
  );
endinterface

// ===== hdl/sem_front.sv =====
// ---------------------------------------------------------------------------
// sem_front
// Accepts items, chains polygon vertices and turns them into edge
// commands for the back end.
// ---------------------------------------------------------------------------
module sem_front #(
  parameter int CB = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sem_in_if.sink                in_ch,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output logic [4*CB-1:0]       cmd_edge_o,
  output sem_pkg::cmd_ctl_t     cmd_ctl_o
);

  localparam int EW = 4 * CB;

  logic                  loading_second_q, loading_second_d;
  logic                  vertex_seen_q, vertex_seen_d;
  logic [2*CB-1:0]       first_q, first_d;
  logic [2*CB-1:0]       prev_q, prev_d;
  logic                  pend_q, pend_d;
  logic [EW-1:0]         pend_edge_q, pend_edge_d;
  sem_pkg::cmd_ctl_t     pend_ctl_q, pend_ctl_d;

  logic [CB-1:0]         xs, ys, xe, ye;
  logic                  accept;
  logic                  is_edge;
  logic                  p0_v, p1_v;
  logic [EW-1:0]         p0_edge, p1_edge;
  sem_pkg::cmd_ctl_t     p0_ctl, p1_ctl;

  assign xs = in_ch.x_start[CB-1:0];
  assign ys = in_ch.y_start[CB-1:0];
  assign xe = in_ch.x_end[CB-1:0];
  assign ye = in_ch.y_end[CB-1:0];

  // a second pending command blocks the next beat
  assign in_ch.ready = !pend_q && cmd_ready_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_edge     = (in_ch.item_kind == sem_pkg::KIND_EDGE);

  // given edge, or the edge chained from the previous vertex
  assign p0_v    = is_edge || vertex_seen_q;
  assign p0_edge = is_edge ? {xs, ys, xe, ye} : {prev_q, xs, ys};

  // closing edge: from the chain's last vertex back to its first
  assign p1_v    = in_ch.body_last && (vertex_seen_q || !is_edge);
  assign p1_edge = {(is_edge ? prev_q : {xs, ys}),
                    ((!is_edge && !vertex_seen_q) ? {xs, ys} : first_q)};

  assign p0_ctl.second      = loading_second_q;
  assign p0_ctl.outline_end = in_ch.body_last && !p1_v;
  assign p1_ctl.second      = loading_second_q;
  assign p1_ctl.outline_end = 1'b1;

  always_comb begin
    if (pend_q) begin
      cmd_valid_o = 1'b1;
      cmd_edge_o  = pend_edge_q;
      cmd_ctl_o   = pend_ctl_q;
    end else begin
      cmd_valid_o = accept && (p0_v || p1_v);
      cmd_edge_o  = p0_v ? p0_edge : p1_edge;
      cmd_ctl_o   = p0_v ? p0_ctl : p1_ctl;
    end
  end

  always_comb begin
    loading_second_d = loading_second_q;
    vertex_seen_d    = vertex_seen_q;
    first_d          = first_q;
    prev_d           = prev_q;
    pend_d           = pend_q;
    pend_edge_d      = pend_edge_q;
    pend_ctl_d       = pend_ctl_q;
    if (pend_q && cmd_ready_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      if (p0_v && p1_v) begin
        pend_d      = 1'b1;
        pend_edge_d = p1_edge;
        pend_ctl_d  = p1_ctl;
      end
      if (!is_edge) begin
        if (!vertex_seen_q) begin
          first_d = {xs, ys};
        end
        vertex_seen_d = 1'b1;
        prev_d        = {xs, ys};
      end
      if (in_ch.body_last) begin
        vertex_seen_d    = 1'b0;
        first_d          = '0;
        prev_d           = '0;
        loading_second_d = !loading_second_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_second_q <= 1'b0;
      vertex_seen_q    <= 1'b0;
      first_q          <= '0;
      prev_q           <= '0;
      pend_q           <= 1'b0;
    end else begin
      loading_second_q <= loading_second_d;
      vertex_seen_q    <= vertex_seen_d;
      first_q          <= first_d;
      prev_q           <= prev_d;
      pend_q           <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_edge_q <= pend_edge_d;
    pend_ctl_q  <= pend_ctl_d;
  end

endmodule

// ===== hdl/sem_queue.sv =====
// ---------------------------------------------------------------------------
// sem_queue
// Short command queue between the front end and the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sem_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  `SEM_ASSERT(a_no_overrun, clk_i, rst_ni, push_i |-> (!full_o || pop_i))
  `SEM_ASSERT(a_no_underrun, clk_i, rst_ni, pop_i |-> valid_o)

endmodule

// ===== hdl/sem_back.sv =====
// ---------------------------------------------------------------------------
// sem_back
// Stores edge commands per outline, marks shared edges pairwise and
// emits the survivors, or one none_left beat when none survive.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sem_back #(
  parameter int MAX = 32,
  parameter int CB  = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_pop_o,
  input  logic [4*CB-1:0]             cmd_edge_i,
  input  sem_pkg::cmd_ctl_t           cmd_ctl_i,
  input  logic [sem_pkg::TOL_W-1:0]   tol_i,
  sem_out_if.source                   out_ch
);

  localparam int EW = 4 * CB;
  localparam int IW = (MAX > 1) ? $clog2(MAX) : 1;
  localparam int CW = $clog2(MAX + 1);
  localparam int SW = $clog2(2 * MAX + 1);
  localparam int DW = (CB + 1 > sem_pkg::TOL_W + 2) ? CB + 1 : sem_pkg::TOL_W + 2;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_NONE  = 3'd6;

  // edge stores, one per outline
  logic [EW-1:0] mem_a [MAX];
  logic [EW-1:0] mem_b [MAX];
  logic [EW-1:0] rd_a_q, rd_b_q;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_a_q, cnt_b_q;
  logic          ovf_q;
  logic [MAX-1:0] mark_a_q, mark_b_q;
  logic [SW-1:0] removed_q, emit_cnt_q;
  logic [IW-1:0] ci_q, cj_q;
  logic          p1_v_q;
  logic [IW-1:0] p1_ia_q, p1_ib_q;
  logic          side_q;
  logic [CW-1:0] pos_q;

  logic          out_v_q;
  logic [EW-1:0] out_edge_q;
  logic          out_second_q, out_none_q, out_ovf_q, out_last_q;

  logic          wr_a, wr_b;
  logic [IW-1:0] wr_idx;
  logic          rd_a_en, rd_b_en;
  logic [IW-1:0] rd_a_idx, rd_b_idx;
  logic [CW-1:0] push_cnt;
  logic          push_full;
  logic          match;
  logic [SW-1:0] surv;
  logic [CW-1:0] lim;
  logic [IW-1:0] pos_idx;
  logic          pos_marked;
  logic          out_free;
  logic          res_load, res_none, res_last;
  logic [EW-1:0] res_edge;
  logic          finish;

  logic signed [CB-1:0] a_xs, a_ys, a_xe, a_ye, b_xs, b_ys, b_xe, b_ye;
  logic signed [CB-1:0] o_xs, o_ys, o_xe, o_ye;

  function automatic logic near_c(input logic signed [CB-1:0] a,
                                  input logic signed [CB-1:0] b,
                                  input logic [sem_pkg::TOL_W-1:0] t);
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] tl;
    d  = DW'(a) - DW'(b);
    tl = $signed(DW'(t));
    return (d <= tl) && (d >= -tl);
  endfunction

  assign a_xs = rd_a_q[EW-1 -: CB];
  assign a_ys = rd_a_q[EW-CB-1 -: CB];
  assign a_xe = rd_a_q[2*CB-1 -: CB];
  assign a_ye = rd_a_q[CB-1:0];
  assign b_xs = rd_b_q[EW-1 -: CB];
  assign b_ys = rd_b_q[EW-CB-1 -: CB];
  assign b_xe = rd_b_q[2*CB-1 -: CB];
  assign b_ye = rd_b_q[CB-1:0];

  // same direction or reversed
  assign match = (near_c(a_xs, b_xs, tol_i) && near_c(a_ys, b_ys, tol_i) &&
                  near_c(a_xe, b_xe, tol_i) && near_c(a_ye, b_ye, tol_i)) ||
                 (near_c(a_xs, b_xe, tol_i) && near_c(a_ys, b_ye, tol_i) &&
                  near_c(a_xe, b_xs, tol_i) && near_c(a_ye, b_ys, tol_i));

  assign cmd_pop_o = (state_q == ST_LOAD) && cmd_valid_i;
  assign push_cnt  = cmd_ctl_i.second ? cnt_b_q : cnt_a_q;
  assign push_full = (push_cnt == CW'(MAX));
  assign wr_idx    = push_cnt[IW-1:0];
  assign wr_a      = cmd_pop_o && !push_full && !cmd_ctl_i.second;
  assign wr_b      = cmd_pop_o && !push_full && cmd_ctl_i.second;

  assign surv       = SW'(cnt_a_q) + SW'(cnt_b_q) - removed_q;
  assign lim        = side_q ? cnt_b_q : cnt_a_q;
  assign pos_idx    = pos_q[IW-1:0];
  assign pos_marked = side_q ? mark_b_q[pos_idx] : mark_a_q[pos_idx];
  assign out_free   = !out_v_q || out_ch.ready;

  always_comb begin
    state_d  = state_q;
    rd_a_en  = 1'b0;
    rd_b_en  = 1'b0;
    rd_a_idx = ci_q;
    rd_b_idx = cj_q;
    res_load = 1'b0;
    res_none = 1'b0;
    res_last = 1'b0;
    res_edge = side_q ? rd_b_q : rd_a_q;
    finish   = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (cmd_pop_o && cmd_ctl_i.outline_end && cmd_ctl_i.second) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = ((cnt_a_q != '0) && (cnt_b_q != '0)) ? ST_CMP : ST_SCAN;
      end
      ST_CMP: begin
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
        if ((CW'(cj_q) == cnt_b_q - 1'b1) && (CW'(ci_q) == cnt_a_q - 1'b1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (surv == '0) begin
          state_d = ST_NONE;
        end else if (pos_q >= lim) begin
          state_d = ST_SCAN;
        end else if (!pos_marked) begin
          rd_a_en  = !side_q;
          rd_b_en  = side_q;
          rd_a_idx = pos_idx;
          rd_b_idx = pos_idx;
          state_d  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          res_load = 1'b1;
          res_last = (emit_cnt_q + 1'b1 == surv);
          finish   = res_last;
          state_d  = res_last ? ST_LOAD : ST_SCAN;
        end
      end
      ST_NONE: begin
        if (out_free) begin
          res_load = 1'b1;
          res_none = 1'b1;
          res_last = 1'b1;
          res_edge = '0;
          finish   = 1'b1;
          state_d  = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      ovf_q      <= 1'b0;
      mark_a_q   <= '0;
      mark_b_q   <= '0;
      removed_q  <= '0;
      emit_cnt_q <= '0;
      ci_q       <= '0;
      cj_q       <= '0;
      p1_v_q     <= 1'b0;
      side_q     <= 1'b0;
      pos_q      <= '0;
      out_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_v_q  <= (state_q == ST_CMP);

      if (cmd_pop_o) begin
        if (push_full) begin
          ovf_q <= 1'b1;
        end else if (cmd_ctl_i.second) begin
          cnt_b_q <= cnt_b_q + 1'b1;
        end else begin
          cnt_a_q <= cnt_a_q + 1'b1;
        end
      end

      if (state_q == ST_START) begin
        ci_q       <= '0;
        cj_q       <= '0;
        side_q     <= 1'b0;
        pos_q      <= '0;
        emit_cnt_q <= '0;
      end

      if (state_q == ST_CMP) begin
        if (CW'(cj_q) == cnt_b_q - 1'b1) begin
          cj_q <= '0;
          ci_q <= ci_q + 1'b1;
        end else begin
          cj_q <= cj_q + 1'b1;
        end
      end

      // mark the pair whose stored edges came back this cycle
      if (p1_v_q && match) begin
        mark_a_q[p1_ia_q] <= 1'b1;
        mark_b_q[p1_ib_q] <= 1'b1;
        removed_q <= removed_q + SW'(!mark_a_q[p1_ia_q]) + SW'(!mark_b_q[p1_ib_q]);
      end

      if (state_q == ST_SCAN && surv != '0) begin
        if (pos_q >= lim) begin
          side_q <= 1'b1;
          pos_q  <= '0;
        end else if (pos_marked) begin
          pos_q <= pos_q + 1'b1;
        end
      end

      if (res_load && !res_none) begin
        emit_cnt_q <= emit_cnt_q + 1'b1;
        pos_q      <= pos_q + 1'b1;
      end

      if (res_load) begin
        out_v_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_q <= 1'b0;
      end

      if (finish) begin
        cnt_a_q   <= '0;
        cnt_b_q   <= '0;
        ovf_q     <= 1'b0;
        mark_a_q  <= '0;
        mark_b_q  <= '0;
        removed_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CMP) begin
      p1_ia_q <= ci_q;
      p1_ib_q <= cj_q;
    end
    if (res_load) begin
      out_edge_q   <= res_edge;
      out_second_q <= res_none ? 1'b0 : side_q;
      out_none_q   <= res_none;
      out_ovf_q    <= ovf_q;
      out_last_q   <= res_last;
    end
  end

  // edge memories
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[wr_idx] <= cmd_edge_i;
    end
    if (rd_a_en) begin
      rd_a_q <= mem_a[rd_a_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[wr_idx] <= cmd_edge_i;
    end
    if (rd_b_en) begin
      rd_b_q <= mem_b[rd_b_idx];
    end
  end

  assign o_xs = out_edge_q[EW-1 -: CB];
  assign o_ys = out_edge_q[EW-CB-1 -: CB];
  assign o_xe = out_edge_q[2*CB-1 -: CB];
  assign o_ye = out_edge_q[CB-1:0];

  assign out_ch.valid       = out_v_q;
  assign out_ch.out_x_start = sem_pkg::FIELD_W'(o_xs);
  assign out_ch.out_y_start = sem_pkg::FIELD_W'(o_ys);
  assign out_ch.out_x_end   = sem_pkg::FIELD_W'(o_xe);
  assign out_ch.out_y_end   = sem_pkg::FIELD_W'(o_ye);
  assign out_ch.from_second = out_second_q;
  assign out_ch.none_left   = out_none_q;
  assign out_ch.overflowed  = out_ovf_q;
  assign out_ch.last_result = out_last_q;

  `SEM_ASSERT(a_emit_bound, clk_i, rst_ni, (state_q == ST_WAIT) |-> (emit_cnt_q < surv))
  `SEM_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, res_load && res_last,
                   (state_q == ST_LOAD) && (removed_q == '0) && (mark_a_q == '0))
  `SEM_ASSERT(a_marks_idle_clear, clk_i, rst_ni,
              (state_q == ST_LOAD) |-> ((mark_a_q == '0) && (mark_b_q == '0)))

endmodule

// ===== hdl/shared_edge_merge.sv =====
// ---------------------------------------------------------------------------
// shared_edge_merge
// Merges two outlines and drops the edges they share.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries vertex or edge items; body_last closes outline A, then B.
//   out_ch carries the surviving edges, A first, last_result on the final
//   beat, or one none_left beat when nothing survives.
//   tolerance sits at APB address 0; write it only while the block is idle.
// Timing:
//   Loading takes one item per cycle while the command queue has room; a
//   body_last beat that closes an open vertex chain makes a closing edge
//   command besides its own and holds off the next beat. A four-entry
//   command queue lets loading run ahead while the back end is busy.
//   After outline B ends, the back end compares every A edge with every B
//   edge, one pair per cycle through two registered memory reads. The emit
//   scan then passes each stored edge of A, skips the marked ones, emits
//   each survivor and moves on to B; it emits one none_left beat when
//   nothing survives.
// Reset clears counts, marks, the vertex chain and the result valid flag;
// tolerance returns to 1. A stalled receiver holds the result beat and the
// scan waits; loading continues until the command queue fills.
// ---------------------------------------------------------------------------
module shared_edge_merge #(
  parameter int MAX_EDGES_PER_OUTLINE = 32,
  parameter int COORD_BITS            = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sem_in_if.sink                        in_ch,
  sem_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sem_pkg::APB_AW-1:0]    paddr,
  input  logic [sem_pkg::APB_DW-1:0]    pwdata,
  output logic [sem_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int EW          = 4 * COORD_BITS;
  localparam int CTL_W       = $bits(sem_pkg::cmd_ctl_t);
  localparam int QW          = EW + CTL_W;
  localparam int QUEUE_DEPTH = 4;

  logic [sem_pkg::TOL_W-1:0] tol_q;

  logic              f_valid, q_full, q_valid, q_pop;
  logic [EW-1:0]     f_edge;
  sem_pkg::cmd_ctl_t f_ctl, q_ctl;
  logic [QW-1:0]     q_data;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == sem_pkg::ADDR_TOLERANCE) ? sem_pkg::APB_DW'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= sem_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == sem_pkg::ADDR_TOLERANCE)) begin
      tol_q <= pwdata[sem_pkg::TOL_W-1:0];
    end
  end

  sem_front #(
    .CB (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (!q_full),
    .cmd_edge_o  (f_edge),
    .cmd_ctl_o   (f_ctl)
  );

  sem_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && !q_full),
    .data_i  ({f_ctl, f_edge}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign q_ctl = q_data[QW-1 -: CTL_W];

  sem_back #(
    .MAX (MAX_EDGES_PER_OUTLINE),
    .CB  (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_edge_i  (q_data[EW-1:0]),
    .cmd_ctl_i   (q_ctl),
    .tol_i       (tol_q),
    .out_ch      (out_ch)
  );

endmodule

// ===== dv/shared_edge_merge_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// shared_edge_merge_tb
// Feeds outline pairs A/B as vertex and edge beats and checks every result
// beat against an in-bench model of the shared edge removal or a table row.
// A short table covers the corner cases first. Random pairs follow, with B
// mostly made from A's own edges, reversed and nudged around the tolerance.
// ---------------------------------------------------------------------------
module shared_edge_merge_tb;

  localparam int MAXE        = 32;
  localparam int CBITS       = 32;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BEATS = 75;

  typedef logic signed [sem_pkg::FIELD_W-1:0] coord_t;

  typedef struct packed {
    logic   kind;
    coord_t xs, ys, xe, ye;
    logic   last;
  } item_t;

  typedef struct packed {
    coord_t xs, ys, xe, ye;
    logic   second, none, ovf, last;
  } merge_res_t;

  typedef struct packed {
    coord_t xs, ys, xe, ye;
  } quad_t;

  typedef struct {
    longint xs, ys, xe, ye;
  } seg_t;

  typedef struct {
    item_t      it;
    int         reps;
    bit         typed;
    merge_res_t res;
  } row_t;

  localparam coord_t MINV = 32'sh8000_0000;
  localparam coord_t MAXV = 32'sh7FFF_FFFF;
  localparam coord_t NEG1 = 32'shFFFF_FFFF;
  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t JUNK = 32'sh5A5A_A5A5;
  localparam coord_t CORNER_VALS [6] = '{MINV, MAXV, 32'sh0, NEG1, MINV + 1, MAXV - 1};

  localparam merge_res_t NO_RES        = '0;
  localparam merge_res_t EMPTY_RUN     = {128'b0, 4'b0101};
  localparam merge_res_t EMPTY_RUN_OVF = {128'b0, 4'b0111};

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel, penable, pwrite;
  logic [sem_pkg::APB_AW-1:0]   paddr;
  logic [sem_pkg::APB_DW-1:0]   pwdata;
  logic [sem_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  sem_in_if  in_ch ();
  sem_out_if out_ch ();

  shared_edge_merge #(
    .MAX_EDGES_PER_OUTLINE(MAXE),
    .COORD_BITS           (CBITS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  seg_t                       seg_store [2][MAXE];
  bit                         seg_gone  [2][MAXE];
  int                         seg_cnt   [2];
  bit                         on_second;
  longint                     fv [2];
  longint                     pv [2];
  bit                         chain_open;
  bit                         run_ovf;
  logic [sem_pkg::TOL_W-1:0]  tol_q = sem_pkg::TOL_RESET;

  merge_res_t        edges_due [$];
  merge_res_t        step_q [$];
  row_t              dir_rows [$];

  int                mismatches = 0;
  int                beats_in = 0;
  int                beats_out = 0;
  int                runs_done = 0;
  int                ovf_runs = 0;
  int                cycle_cnt = 0;
  bit                rx_steady = 1'b0;

  function automatic longint sext_coord(coord_t raw);
    logic [31:0] v;
    v = raw & (32'hFFFF_FFFF >> (32 - CBITS));
    if (v[CBITS-1]) return longint'({32'b0, v}) - (longint'(1) << CBITS);
    return longint'({32'b0, v});
  endfunction

  function automatic bit close_pt(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, lim;
    lim = longint'({48'b0, tol_q});
    dx = ax - bx;
    dy = ay - by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx <= lim && dy <= lim;
  endfunction

  function automatic bit same_seg(seg_t p, seg_t q);
    if (close_pt(p.xs, p.ys, q.xs, q.ys) && close_pt(p.xe, p.ye, q.xe, q.ye)) return 1'b1;
    return close_pt(p.xs, p.ys, q.xe, q.ye) && close_pt(p.xe, p.ye, q.xs, q.ys);
  endfunction

  function automatic void store_seg(longint xs, longint ys, longint xe, longint ye);
    int s;
    s = on_second;
    if (seg_cnt[s] >= MAXE) begin
      run_ovf = 1'b1;
      return;
    end
    seg_store[s][seg_cnt[s]] = '{xs, ys, xe, ye};
    seg_cnt[s]++;
  endfunction

  // One accepted beat; result beats of a finished merge go to step_q.
  function automatic void edge_merge_step(item_t it);
    longint     xs, ys, xe, ye;
    merge_res_t r;
    seg_t       t;
    xs = sext_coord(it.xs);
    ys = sext_coord(it.ys);
    xe = sext_coord(it.xe);
    ye = sext_coord(it.ye);
    if (it.kind == sem_pkg::KIND_EDGE) begin
      store_seg(xs, ys, xe, ye);
    end else begin
      if (chain_open) begin
        store_seg(pv[0], pv[1], xs, ys);
      end else begin
        fv[0] = xs;
        fv[1] = ys;
        chain_open = 1'b1;
      end
      pv[0] = xs;
      pv[1] = ys;
    end
    if (!it.last) return;

    if (chain_open) store_seg(pv[0], pv[1], fv[0], fv[1]);
    chain_open = 1'b0;
    fv = '{0, 0};
    pv = '{0, 0};
    if (!on_second) begin
      on_second = 1'b1;
      return;
    end

    for (int i = 0; i < seg_cnt[0]; i++)
      for (int j = 0; j < seg_cnt[1]; j++)
        if (same_seg(seg_store[0][i], seg_store[1][j])) begin
          seg_gone[0][i] = 1'b1;
          seg_gone[1][j] = 1'b1;
        end

    for (int s = 0; s < 2; s++)
      for (int i = 0; i < seg_cnt[s]; i++)
        if (!seg_gone[s][i]) begin
          t = seg_store[s][i];
          r.xs = t.xs[sem_pkg::FIELD_W-1:0];
          r.ys = t.ys[sem_pkg::FIELD_W-1:0];
          r.xe = t.xe[sem_pkg::FIELD_W-1:0];
          r.ye = t.ye[sem_pkg::FIELD_W-1:0];
          r.second = (s == 1);
          r.none = 1'b0;
          r.ovf = run_ovf;
          r.last = 1'b0;
          step_q.insert(step_q.size(), r);
        end
    if (step_q.size() == 0) begin
      r = '0;
      r.none = 1'b1;
      r.last = 1'b1;
      r.ovf = run_ovf;
      step_q.insert(step_q.size(), r);
    end else begin
      step_q[step_q.size()-1].last = 1'b1;
    end

    for (int s = 0; s < 2; s++) begin
      seg_cnt[s] = 0;
      for (int i = 0; i < MAXE; i++) seg_gone[s][i] = 1'b0;
    end
    on_second = 1'b0;
    run_ovf = 1'b0;
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endtask

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic coord_t rnd_coord();
    int g;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        // coarse grid so that edges of A and B meet by chance
        g = int'($urandom_range(0, 7)) - 4;
        return coord_t'(g * 65536 + int'($urandom_range(0, 1)));
      end
      6, 7:    return coord_t'($urandom);
      8:       return CORNER_VALS[$urandom_range(0, 5)];
      default: return coord_t'(int'($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  // move a coordinate by up to one step past the tolerance either way
  function automatic coord_t nudge(coord_t c);
    int span;
    span = int'(tol_q) + 1;
    return c + coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic item_t rnd_item(logic kind);
    item_t it;
    it.kind = kind;
    it.xs = rnd_coord();
    it.ys = rnd_coord();
    it.xe = rnd_coord();
    it.ye = rnd_coord();
    it.last = 1'b0;
    return it;
  endfunction

  function automatic void add_row(logic kind, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                                  logic last, int reps, bit typed, merge_res_t res);
    row_t r;
    r.it = '{kind: kind, xs: xs, ys: ys, xe: xe, ye: ye, last: last};
    r.reps = reps;
    r.typed = typed;
    r.res = res;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  task automatic feed(item_t it, bit idle_on, bit typed, merge_res_t typed_res);
    int gap;
    gap = idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.item_kind <= it.kind;
    in_ch.x_start   <= it.xs;
    in_ch.y_start   <= it.ys;
    in_ch.x_end     <= it.xe;
    in_ch.y_end     <= it.ye;
    in_ch.body_last <= it.last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    beats_in++;
    step_q.delete();
    edge_merge_step(it);
    if (typed) edges_due.insert(edges_due.size(), typed_res);
    else foreach (step_q[k]) edges_due.insert(edges_due.size(), step_q[k]);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (edges_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic read_tolerance();
    logic [sem_pkg::APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= sem_pkg::ADDR_TOLERANCE;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== sem_pkg::APB_DW'(tol_q))
      report($sformatf("tolerance read back %h, want %h", got, sem_pkg::APB_DW'(tol_q)));
  endtask

  task automatic set_tolerance(logic [sem_pkg::TOL_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sem_pkg::ADDR_TOLERANCE;
    pwdata  <= sem_pkg::APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tol_q = value;
    @(posedge clk_i);
    read_tolerance();
  endtask

  // One A/B pair. B is mostly A's own edges, some reversed or nudged.
  task automatic gen_pair(bit idle_on);
    item_t  a_items [$];
    item_t  b_items [$];
    quad_t  a_quads [$];
    coord_t vx [$];
    coord_t vy [$];
    item_t  it;
    quad_t  q;
    coord_t fx, fy, px, py;
    int     na, nb, style;
    bit     chained;
    na = ($urandom_range(0, 11) == 0) ? $urandom_range(MAXE - 2, MAXE + 2)
                                      : $urandom_range(1, 6);
    style = $urandom_range(0, 2);
    chained = 1'b0;
    fx = '0; fy = '0; px = '0; py = '0;
    for (int i = 0; i < na; i++) begin
      it = rnd_item((style == 0) ? sem_pkg::KIND_VERTEX :
                    (style == 1) ? sem_pkg::KIND_EDGE : logic'($urandom_range(0, 1)));
      it.last = (i == na - 1);
      if (it.kind == sem_pkg::KIND_EDGE) begin
        a_quads.insert(a_quads.size(), quad_t'({it.xs, it.ys, it.xe, it.ye}));
      end else begin
        if (chained) begin
          a_quads.insert(a_quads.size(), quad_t'({px, py, it.xs, it.ys}));
        end else begin
          fx = it.xs;
          fy = it.ys;
          chained = 1'b1;
        end
        px = it.xs;
        py = it.ys;
        vx.insert(vx.size(), it.xs);
        vy.insert(vy.size(), it.ys);
      end
      a_items.insert(a_items.size(), it);
    end
    if (chained) a_quads.insert(a_quads.size(), quad_t'({px, py, fx, fy}));

    if (style == 0 && $urandom_range(0, 3) == 0) begin
      // same polygon walked backwards
      for (int i = vx.size() - 1; i >= 0; i--) begin
        it = rnd_item(sem_pkg::KIND_VERTEX);
        it.xs = $urandom_range(0, 3) == 0 ? nudge(vx[i]) : vx[i];
        it.ys = $urandom_range(0, 3) == 0 ? nudge(vy[i]) : vy[i];
        b_items.insert(b_items.size(), it);
      end
    end else if ($urandom_range(0, 4) == 0) begin
      nb = $urandom_range(1, 6);
      for (int i = 0; i < nb; i++)
        b_items.insert(b_items.size(), rnd_item(logic'($urandom_range(0, 1))));
    end else begin
      foreach (a_quads[i]) begin
        if ($urandom_range(0, 3) != 0) begin
          q = a_quads[i];
          if ($urandom_range(0, 1)) q = {q.xe, q.ye, q.xs, q.ys};
          if ($urandom_range(0, 1)) begin
            q.xs = nudge(q.xs);
            q.ys = nudge(q.ys);
            q.xe = nudge(q.xe);
            q.ye = nudge(q.ye);
          end
          it = '{kind: sem_pkg::KIND_EDGE, xs: q.xs, ys: q.ys, xe: q.xe, ye: q.ye,
                 last: 1'b0};
          b_items.insert(b_items.size(), it);
        end
        if ($urandom_range(0, 4) == 0)
          b_items.insert(b_items.size(), rnd_item(sem_pkg::KIND_EDGE));
      end
    end
    if (b_items.size() == 0) b_items.insert(b_items.size(), rnd_item(sem_pkg::KIND_EDGE));
    b_items[b_items.size()-1].last = 1'b1;

    foreach (a_items[i]) feed(a_items[i], idle_on, 1'b0, NO_RES);
    foreach (b_items[i]) feed(b_items[i], idle_on, 1'b0, NO_RES);
  endtask

  // result side: check each beat, stall at random
  initial begin : result_sink
    merge_res_t got;
    merge_res_t want;
    int         stall;
    stall = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.out_x_start, out_ch.out_y_start, out_ch.out_x_end, out_ch.out_y_end,
               out_ch.from_second, out_ch.none_left, out_ch.overflowed, out_ch.last_result};
        beats_out++;
        if (got.last === 1'b1) runs_done++;
        if (got.last === 1'b1 && got.ovf === 1'b1) ovf_runs++;
        if (edges_due.size() == 0) begin
          report($sformatf("unexpected result beat %h %h %h %h sec %b none %b ovf %b last %b",
                           got.xs, got.ys, got.xe, got.ye,
                           got.second, got.none, got.ovf, got.last));
        end else begin
          want = edges_due.pop_front();
          if (got !== want)
            report($sformatf({"result beat %0d: want %h %h %h %h sec %b none %b ovf %b last %b",
                              ", got %h %h %h %h sec %b none %b ovf %b last %b"},
                             beats_out, want.xs, want.ys, want.xe, want.ye, want.second,
                             want.none, want.ovf, want.last, got.xs, got.ys, got.xe,
                             got.ye, got.second, got.none, got.ovf, got.last));
        end
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall = rx_steady ? 0 : idle_len();
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d result beats outstanding",
             cycle_cnt, edges_due.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [sem_pkg::TOL_W-1:0] tol_plan [4];
    int                        target;
    in_ch.valid     = 1'b0;
    in_ch.item_kind = sem_pkg::KIND_VERTEX;
    in_ch.x_start   = '0;
    in_ch.y_start   = '0;
    in_ch.x_end     = '0;
    in_ch.y_end     = '0;
    in_ch.body_last = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;

    // equal when reversed, reset tolerance
    add_row(sem_pkg::KIND_EDGE, 0, 0, 10 * ONE, 0, 1'b1, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, 10 * ONE, 0, 0, 0, 1'b1, 1, 1'b1, EMPTY_RUN);
    // extremes, one LSB apart
    add_row(sem_pkg::KIND_EDGE, MINV, MINV, MAXV, MAXV, 1'b1, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, MINV + 1, MINV, MAXV, MAXV - 1, 1'b1, 1, 1'b1, EMPTY_RUN);
    // two LSBs apart: both survive
    add_row(sem_pkg::KIND_EDGE, MAXV, MINV, 0, 0, 1'b1, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, MAXV - 2, MINV, 0, 0, 1'b1, 1, 1'b0, NO_RES);
    // triangles sharing one side
    add_row(sem_pkg::KIND_VERTEX, 0, 0, JUNK, JUNK, 1'b0, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_VERTEX, ONE, 0, JUNK, JUNK, 1'b0, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_VERTEX, ONE, ONE, JUNK, JUNK, 1'b1, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_VERTEX, ONE, 0, ~JUNK, ~JUNK, 1'b0, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_VERTEX, 0, 0, ~JUNK, ~JUNK, 1'b0, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_VERTEX, 0, -ONE, JUNK, ~JUNK, 1'b1, 1, 1'b0, NO_RES);
    // one vertex per outline: zero-length closing edges
    add_row(sem_pkg::KIND_VERTEX, 5, 5, 0, 0, 1'b1, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_VERTEX, 5, 5, NEG1, NEG1, 1'b1, 1, 1'b1, EMPTY_RUN);
    // mixed kinds, the chain closes on an edge beat
    add_row(sem_pkg::KIND_VERTEX, 0, 0, JUNK, JUNK, 1'b0, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, 3 * ONE, 3 * ONE, 4 * ONE, 4 * ONE, 1'b0, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_VERTEX, 2 * ONE, 0, JUNK, JUNK, 1'b0, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, 9, 9, 8, 8, 1'b1, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, 0, 0, 2 * ONE, 0, 1'b0, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, 8, 8, 9, 9, 1'b0, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, NEG1, NEG1, NEG1, 0, 1'b1, 1, 1'b0, NO_RES);
    // full range reversed
    add_row(sem_pkg::KIND_EDGE, MAXV, MAXV, MINV, MINV, 1'b1, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, MINV, MINV, MAXV, MAXV, 1'b1, 1, 1'b1, EMPTY_RUN);
    // outline A runs out of slots
    add_row(sem_pkg::KIND_EDGE, ONE, ONE, 2 * ONE, 2 * ONE, 1'b0, MAXE + 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, ONE, ONE, 2 * ONE, 2 * ONE, 1'b1, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_EDGE, 2 * ONE, 2 * ONE, ONE, ONE, 1'b1, 1, 1'b1, EMPTY_RUN_OVF);
    // A full before its closing edge
    add_row(sem_pkg::KIND_VERTEX, 7, 7, 0, 0, 1'b0, MAXE, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_VERTEX, 7, 7, 0, 0, 1'b1, 1, 1'b0, NO_RES);
    add_row(sem_pkg::KIND_VERTEX, 7, 7, 0, 0, 1'b1, 1, 1'b1, EMPTY_RUN_OVF);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);
    read_tolerance();

    foreach (dir_rows[i])
      for (int r = 0; r < dir_rows[i].reps; r++)
        feed(dir_rows[i].it, $urandom_range(0, 2) == 0,
             dir_rows[i].typed && (r == dir_rows[i].reps - 1), dir_rows[i].res);
    wait_for_results();

    tol_plan = '{16'd0, 16'hFFFF, sem_pkg::TOL_W'($urandom_range(2, 400)),
                 sem_pkg::TOL_W'($urandom)};
    for (int phase = 0; phase < 4; phase++) begin
      set_tolerance(tol_plan[phase]);
      rx_steady = (phase == 1);
      target = beats_in + PHASE_BEATS;
      while (beats_in < target) begin
        gen_pair($urandom_range(0, 3) != 0);
        // sender holds off until the block has drained
        if ($urandom_range(0, 11) == 0) wait_for_results();
      end
      wait_for_results();
    end

    $display("Covered %0d input beats and %0d result beats over %0d merges (%0d overflowed)",
             beats_in, beats_out, runs_done, ovf_runs);
    $display("Tolerance settings: reset value, 0x%h, 0x%h, 0x%h, 0x%h",
             tol_plan[0], tol_plan[1], tol_plan[2], tol_plan[3]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sem_pkg.sv
hdl/sem_in_if.sv
hdl/sem_out_if.sv
hdl/sem_front.sv
hdl/sem_queue.sv
hdl/sem_back.sv
hdl/shared_edge_merge.sv
dv/shared_edge_merge_tb.sv
